[rtl/mvm_pkg.sv]
// shared types, constants and arithmetic helpers of the matrix-vector multiplier
// used by mvm_cell and matrix_vector_multiply; no dependencies
package mvm_pkg;

    localparam int MAX_DIM    = 16;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_W      = 4;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 2 * VALUE_BITS;
    localparam int SUM_W      = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_VECTOR = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [IDX_W-1:0]             row_index;
        logic [IDX_W-1:0]             col_index;
        logic signed [VALUE_BITS-1:0] value;
        logic                         is_last;
    } item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] result;
        logic [IDX_W-1:0]        out_row;
        logic                    last;
        logic                    size_error;
    } res_t;

    // vector element travelling down the chain of cells
    typedef struct packed {
        logic                         vld;
        logic                         first;
        logic                         lastcol;
        logic [ADDR_W-1:0]            col;
        logic signed [VALUE_BITS-1:0] x;
    } tok_t;

    // matrix entry write into one row cell
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [VALUE_BITS-1:0] data;
    } mat_wr_t;

    // register value to dimension in use: zero acts as one, large values clamp
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] cfg);
        logic [DIM_W-1:0] dim;
        if (cfg == '0)
            dim = DIM_W'(1);
        else if (int'(cfg) > MAX_DIM)
            dim = DIM_W'(MAX_DIM);
        else
            dim = DIM_W'(cfg);
        return dim;
    endfunction

    // accumulate with saturation to the signed accumulator range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [ACC_W-1:0] r;
        hi = $signed({{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        s  = SUM_W'(acc) + SUM_W'(prod);
        if (s > hi)
            r = hi[ACC_W-1:0];
        else if (s < lo)
            r = lo[ACC_W-1:0];
        else
            r = s[ACC_W-1:0];
        return r;
    endfunction

endpackage

[rtl/mvm_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mvm_cell.sv]
// one row cell: holds a matrix row, multiplies passing vector elements, accumulates
// depends on mvm_pkg and mvm_ram
module mvm_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mvm_pkg::mat_wr_t                       wr,
    input  mvm_pkg::tok_t                          tok_in,
    output mvm_pkg::tok_t                          tok_out,
    input  logic                                   shift,
    input  logic signed [mvm_pkg::ACC_W-1:0]       acc_in,
    output logic signed [mvm_pkg::ACC_W-1:0]       acc
);

    logic [mvm_pkg::VALUE_BITS-1:0]    coef;
    mvm_pkg::tok_t                     tok_reg;
    logic signed [mvm_pkg::PROD_W-1:0] prod_next;
    logic signed [mvm_pkg::PROD_W-1:0] prod_reg;
    logic                              pvld_reg;
    logic                              pfirst_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_next;

    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_BITS),
        .DEPTH (mvm_pkg::MAX_DIM)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr.we),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (tok_in.vld),
        .rd_addr (tok_in.col),
        .rd_data (coef)
    );

    assign prod_next = mvm_pkg::PROD_W'($signed(coef)) * mvm_pkg::PROD_W'(tok_reg.x);

    always_comb
    begin
        if (shift)
            acc_next = acc_in;
        else if (pvld_reg)
            acc_next = mvm_pkg::sat_add(pfirst_reg ? '0 : acc_reg, prod_reg);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            pvld_reg   <= 1'b0;
            pfirst_reg <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_in;
            pvld_reg   <= tok_reg.vld;
            pfirst_reg <= tok_reg.first;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign tok_out = tok_reg;
    assign acc     = acc_reg;

endmodule

[rtl/matrix_vector_multiply.sv]
// top level of the matrix-vector multiplier: config registers, sequencer, chain of row cells
// depends on mvm_pkg, mvm_ram and mvm_cell
//
// Matrix and vector entries are taken one per cycle and written straight into
// per-row memories (one mvm_cell per row) and a vector memory. The vector entry
// flagged is_last starts a run: if its position plus one differs from num_cols,
// one error result follows at once. Otherwise the vector is walked out one
// element per cycle into a chain of MAX_DIM row cells; each element moves one
// cell down per cycle, and every cell multiplies it by its own matrix entry and
// accumulates with saturation at 40 bits. A run keeps the input stalled through
// the column walk and the trip down the chain, and then delivers num_rows results,
// one per cycle when the output does not stall, by shifting the accumulators
// toward cell 0; the input stays stalled until the last result is taken.
// Entry loads keep the full rate of one transfer per cycle.
// Configuration may only be written while no run is in progress; a register
// value of 0 acts as 1 and values above MAX_DIM act as MAX_DIM. Matrix and
// vector memories have no reset and must be written before they are used.
module matrix_vector_multiply (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  mvm_pkg::item_t                   item,
    output logic                             res_valid,
    input  logic                             res_stall,
    output mvm_pkg::res_t                    res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FEED  = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_ERROR = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [mvm_pkg::CFG_W-1:0]  rows_reg;
    logic [mvm_pkg::CFG_W-1:0]  cols_reg;
    logic [mvm_pkg::DIM_W-1:0]  rows_eff;
    logic [mvm_pkg::DIM_W-1:0]  cols_eff;

    // handshakes
    logic item_xfer;
    logic res_xfer;
    logic run_start;
    logic len_bad;

    // feed of vector elements into the chain
    logic [mvm_pkg::ADDR_W-1:0] feed_cnt_reg;
    logic [mvm_pkg::ADDR_W-1:0] feed_cnt_next;
    logic                       feed_end;
    logic                       feed_vld_reg;
    logic                       feed_first_reg;
    logic                       feed_lastcol_reg;
    logic [mvm_pkg::ADDR_W-1:0] feed_col_reg;
    logic [mvm_pkg::VALUE_BITS-1:0] vec_q;

    // result drain
    logic [mvm_pkg::ADDR_W-1:0] out_cnt_reg;
    logic [mvm_pkg::ADDR_W-1:0] out_cnt_next;
    logic                       out_end;

    // last token leaves the chain; its sum is settled once the flag reaches tail_reg[1]
    logic [1:0] tail_reg;

    // cell chain
    mvm_pkg::tok_t                    tok [mvm_pkg::MAX_DIM+1];
    logic signed [mvm_pkg::ACC_W-1:0] acc [mvm_pkg::MAX_DIM+1];
    logic                             shift;
    logic                             mat_hit;

    assign rows_eff = mvm_pkg::eff_dim(rows_reg);
    assign cols_eff = mvm_pkg::eff_dim(cols_reg);

    assign item_stall = (state_reg != ST_IDLE);
    assign item_xfer  = item_valid && !item_stall;
    assign res_valid  = (state_reg == ST_DRAIN) || (state_reg == ST_ERROR);
    assign res_xfer   = res_valid && !res_stall;

    assign run_start = item_xfer && (item.kind == mvm_pkg::KIND_VECTOR) && item.is_last;
    assign len_bad   = (32'(item.col_index) + 32'd1) != 32'(cols_eff);

    assign feed_end = (32'(feed_cnt_reg) + 32'd1) == 32'(cols_eff);
    assign out_end  = (32'(out_cnt_reg) + 32'd1) == 32'(rows_eff);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= mvm_pkg::CFG_W'(mvm_pkg::MAX_DIM);
            cols_reg <= mvm_pkg::CFG_W'(mvm_pkg::MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvm_pkg::REG_NUM_ROWS: rows_reg <= cfg_data;
                mvm_pkg::REG_NUM_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        feed_cnt_next = feed_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_start)
                begin
                    feed_cnt_next = '0;
                    state_next    = len_bad ? ST_ERROR : ST_FEED;
                end
            end
            ST_FEED:
            begin
                feed_cnt_next = feed_cnt_reg + mvm_pkg::ADDR_W'(1);
                if (feed_end)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                out_cnt_next = '0;
                if (tail_reg[1])
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (res_xfer)
                begin
                    out_cnt_next = out_cnt_reg + mvm_pkg::ADDR_W'(1);
                    if (out_end)
                        state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (res_xfer)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            feed_cnt_reg     <= '0;
            out_cnt_reg      <= '0;
            feed_vld_reg     <= 1'b0;
            feed_first_reg   <= 1'b0;
            feed_lastcol_reg <= 1'b0;
            feed_col_reg     <= '0;
            tail_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            feed_cnt_reg     <= feed_cnt_next;
            out_cnt_reg      <= out_cnt_next;
            feed_vld_reg     <= (state_reg == ST_FEED);
            feed_first_reg   <= (state_reg == ST_FEED) && (feed_cnt_reg == '0);
            feed_lastcol_reg <= (state_reg == ST_FEED) && feed_end;
            feed_col_reg     <= feed_cnt_reg;
            tail_reg         <= {tail_reg[0], tok[mvm_pkg::MAX_DIM].vld &&
                                              tok[mvm_pkg::MAX_DIM].lastcol};
        end
    end

    // vector memory: written on each vector transfer, read during the feed
    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_BITS),
        .DEPTH (mvm_pkg::MAX_DIM)
    ) u_vec_ram (
        .clk     (clk),
        .wr_en   (item_xfer && (item.kind == mvm_pkg::KIND_VECTOR) &&
                  (32'(item.col_index) < 32'(mvm_pkg::MAX_DIM))),
        .wr_addr (mvm_pkg::ADDR_W'(item.col_index)),
        .wr_data (item.value),
        .rd_en   (state_reg == ST_FEED),
        .rd_addr (feed_cnt_reg),
        .rd_data (vec_q)
    );

    // element enters cell 0 together with its memory read data
    assign tok[0].vld     = feed_vld_reg;
    assign tok[0].first   = feed_first_reg;
    assign tok[0].lastcol = feed_lastcol_reg;
    assign tok[0].col     = feed_col_reg;
    assign tok[0].x       = $signed(vec_q);

    // accumulators move toward cell 0 on each result transfer of the drain
    assign shift = (state_reg == ST_DRAIN) && res_xfer;
    assign acc[mvm_pkg::MAX_DIM] = '0;

    assign mat_hit = item_xfer && (item.kind == mvm_pkg::KIND_MATRIX) &&
                     (32'(item.col_index) < 32'(mvm_pkg::MAX_DIM));

    for (genvar r = 0; r < mvm_pkg::MAX_DIM; r++)
    begin : g_cell
        mvm_pkg::mat_wr_t wr;

        assign wr.we   = mat_hit && (32'(item.row_index) == r);
        assign wr.addr = mvm_pkg::ADDR_W'(item.col_index);
        assign wr.data = item.value;

        mvm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (tok[r]),
            .tok_out (tok[r+1]),
            .shift   (shift),
            .acc_in  (acc[r+1]),
            .acc     (acc[r])
        );
    end

    // result payload: the error result, or the head of the accumulator chain
    always_comb
    begin
        if (state_reg == ST_ERROR)
        begin
            res.result     = '0;
            res.out_row    = '0;
            res.last       = 1'b1;
            res.size_error = 1'b1;
        end
        else
        begin
            res.result     = acc[0];
            res.out_row    = mvm_pkg::IDX_W'(out_cnt_reg);
            res.last       = out_end;
            res.size_error = 1'b0;
        end
    end

    // a result is only offered while the input side is held off
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> item_stall)
        else $error("result offered while input accepted");

    // the final result of a run returns the block to accepting entries
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && res.last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after last result");

    // elements only travel the chain during a run's compute phase
    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok[mvm_pkg::MAX_DIM].vld |-> ((state_reg == ST_FEED) || (state_reg == ST_WAIT)))
        else $error("chain active outside compute phase");

    // an error run never starts the column walk
    a_err_no_feed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERROR) |-> !feed_vld_reg)
        else $error("feed active during error result");

endmodule

[dv/mvm_tb_pkg.sv]
`timescale 1ns / 1ps
// scoreboard for the matrix-vector multiplier testbench: mirrors matrix, vector and dimensions
// and predicts the row sums each transfer causes; depends on mvm_pkg
package mvm_tb_pkg;

    import mvm_pkg::*;

    localparam longint SUM_TOP    = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint SUM_BOTTOM = -SUM_TOP - 1;
    localparam int     SHOW_LIMIT = 10;

    class dot_product_board;

        logic signed [VALUE_BITS-1:0] matrix_copy [MAX_DIM][MAX_DIM];
        logic signed [VALUE_BITS-1:0] vector_copy [MAX_DIM];
        logic [CFG_W-1:0]             rows_reg;
        logic [CFG_W-1:0]             cols_reg;
        res_t                         expected_sums [$];
        int unsigned                  mismatches;
        int unsigned                  results_seen;
        int unsigned                  size_errors;

        function new();
            rows_reg     = CFG_W'(MAX_DIM);
            cols_reg     = CFG_W'(MAX_DIM);
            mismatches   = 0;
            results_seen = 0;
            size_errors  = 0;
        endfunction

        function int unsigned dim_in_use(logic [CFG_W-1:0] reg_value);
            if (reg_value == '0)
                return 1;
            return (int'(reg_value) > MAX_DIM) ? MAX_DIM : int'(reg_value);
        endfunction

        // spare indexes fall through and change nothing
        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index == REG_NUM_ROWS)
                rows_reg = data;
            else if (index == REG_NUM_COLS)
                cols_reg = data;
        endfunction

        function int unsigned pending();
            return expected_sums.size();
        endfunction

        function void take_item(item_t entry);
            int unsigned rows;
            int unsigned cols;
            longint      acc;
            res_t        want;
            if (entry.kind == KIND_MATRIX)
            begin
                matrix_copy[entry.row_index][entry.col_index] = entry.value;
                return;
            end
            vector_copy[entry.col_index] = entry.value;
            if (!entry.is_last)
                return;
            rows = dim_in_use(rows_reg);
            cols = dim_in_use(cols_reg);
            if (int'(entry.col_index) + 1 != cols)
            begin
                want            = '0;
                want.last       = 1'b1;
                want.size_error = 1'b1;
                expected_sums   = {expected_sums, want};
                return;
            end
            for (int r = 0; r < rows; r++)
            begin
                acc = 0;
                for (int c = 0; c < cols; c++)
                begin
                    acc += longint'(matrix_copy[r][c]) * longint'(vector_copy[c]);
                    if (acc > SUM_TOP)
                        acc = SUM_TOP;
                    else if (acc < SUM_BOTTOM)
                        acc = SUM_BOTTOM;
                end
                want.result     = acc[ACC_W-1:0];
                want.out_row    = IDX_W'(r);
                want.last       = (r == rows - 1);
                want.size_error = 1'b0;
                expected_sums   = {expected_sums, want};
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            results_seen++;
            if (expected_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t result with nothing expected: %s %0d row %0d last %0b err %0b",
                             $time, "result", got.result, got.out_row, got.last,
                             got.size_error);
                return;
            end
            want = expected_sums.pop_front();
            if (want.size_error)
                size_errors++;
            if (got.result !== want.result || got.out_row !== want.out_row ||
                got.last !== want.last || got.size_error !== want.size_error)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                begin
                    $display("%0t mismatch: expected result %0d row %0d last %0b err %0b",
                             $time, want.result, want.out_row, want.last, want.size_error);
                    $display("%0t          got      result %0d row %0d last %0b err %0b",
                             $time, got.result, got.out_row, got.last, got.size_error);
                end
            end
        endfunction

    endclass

endpackage

[dv/tb_matrix_vector_multiply.sv]
`timescale 1ns / 1ps
// testbench of matrix_vector_multiply: directed corner items, then random load/multiply runs
// under four idle/stall phases; depends on mvm_pkg, mvm_tb_pkg and the block's rtl
module tb_matrix_vector_multiply;

    import mvm_pkg::*;
    import mvm_tb_pkg::*;

    // register indexes beyond the two real ones, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam int RANDOM_ITEMS = 230;
    localparam int PHASES       = 4;
    // extra wait after the last expected sum so a run can finish; give it a margin
    localparam int DRAIN_CYCLES = 2 * MAX_DIM + 8;
    localparam int QUIET_LIMIT  = 5000;
    // plan entries at or above this tag are vector positions
    localparam int VEC_TAG      = 1000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic        item_valid;
    logic        item_stall;
    item_t       entry_in;
    logic        res_valid;
    logic        res_stall;
    res_t        sum_out;

    dot_product_board board;

    // stimulus bookkeeping: which store entries hold data, dimensions in use
    bit          mat_written [MAX_DIM][MAX_DIM];
    bit          vec_written [MAX_DIM];
    int          eff_rows;
    int          eff_cols;
    int          idle_pct;
    int          stall_pct;
    int unsigned items_sent;
    int unsigned cfg_writes;
    int unsigned quiet_cycles;

    matrix_vector_multiply i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (entry_in),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (sum_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: stall decided fresh at every falling edge
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            res_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: sample both channels and the config port at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.write_register(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                board.take_item(entry_in);
            if (res_valid && !res_stall)
                board.check_result(sum_out);
            if ((item_valid && !item_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: too long without any transfer means the block hung
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, board.pending());
        $display("CHECK FAILED");
        $finish;
    end

    // one input transfer: random idle cycles first, then hold until not stalled
    task automatic send_item(input item_t entry);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        entry_in   = entry;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic load(input logic kind, input int row, input int col,
                        input logic signed [VALUE_BITS-1:0] value, input logic last_flag);
        item_t entry;
        entry.kind      = kind;
        entry.row_index = IDX_W'(row);
        entry.col_index = IDX_W'(col);
        entry.value     = value;
        entry.is_last   = last_flag;
        if (kind == KIND_MATRIX)
            mat_written[row][col] = 1'b1;
        else
            vec_written[col] = 1'b1;
        send_item(entry);
        items_sent++;
    endtask

    // sender quiet, every expected sum delivered, then let the block run dry
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_writes++;
        if (index == REG_NUM_ROWS)
            eff_rows = board.dim_in_use(data);
        else if (index == REG_NUM_COLS)
            eff_cols = board.dim_in_use(data);
    endtask

    task automatic configure(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
        settle();
        write_config(REG_NUM_ROWS, rows_val);
        write_config(REG_NUM_COLS, cols_val);
        if ($urandom_range(0, 3) == 0)
            write_config($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    endtask

    // mostly small dimensions, sometimes zero, exactly max, or above max
    function automatic logic [CFG_W-1:0] pick_dim_reg();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(MAX_DIM);
            2:       return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // a full-size square would need every matrix entry loaded, keep one side small
    task automatic configure_random();
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;
        rows_val = pick_dim_reg();
        cols_val = pick_dim_reg();
        if (board.dim_in_use(rows_val) == MAX_DIM && board.dim_in_use(cols_val) == MAX_DIM)
            cols_val = CFG_W'($urandom_range(1, 4));
        configure(rows_val, cols_val);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] rand_value();
        logic signed [VALUE_BITS-1:0] v;
        v = VALUE_BITS'($urandom);
        case ($urandom_range(0, 7))
            0: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
            1: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
            2: v = '0;
            3: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // stray entries: vector without is_last, or matrix entry carrying is_last
    task automatic send_noise();
        if ($urandom_range(0, 1))
            load(KIND_VECTOR, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(), 1'b0);
        else
            load(KIND_MATRIX, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(), 1'b1);
    endtask

    // vector closed at the wrong length: one error result, no store read
    task automatic send_bad_length();
        int col;
        do
            col = $urandom_range(0, 15);
        while (col == eff_cols - 1);
        load(KIND_VECTOR, $urandom_range(0, 15), col, rand_value(), 1'b1);
    endtask

    // well-formed run: load whatever is still unwritten plus a random share of the rest,
    // in shuffled order with some noise mixed in, then close the vector at num_cols
    task automatic run_product();
        int plan [$];
        int pick;
        int tmp;
        for (int r = 0; r < eff_rows; r++)
            for (int c = 0; c < eff_cols; c++)
                if (!mat_written[r][c] || $urandom_range(0, 1))
                    plan = {plan, r * MAX_DIM + c};
        for (int c = 0; c < eff_cols - 1; c++)
            if (!vec_written[c] || $urandom_range(0, 1))
                plan = {plan, VEC_TAG + c};
        for (int k = plan.size() - 1; k > 0; k--)
        begin
            pick       = $urandom_range(0, k);
            tmp        = plan[k];
            plan[k]    = plan[pick];
            plan[pick] = tmp;
        end
        foreach (plan[n])
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            if (plan[n] >= VEC_TAG)
                load(KIND_VECTOR, $urandom_range(0, 15), plan[n] - VEC_TAG, rand_value(), 1'b0);
            else
                load(KIND_MATRIX, plan[n] / MAX_DIM, plan[n] % MAX_DIM, rand_value(),
                     logic'($urandom_range(0, 1)));
        end
        load(KIND_VECTOR, $urandom_range(0, 15), eff_cols - 1, rand_value(), 1'b1);
    endtask

    initial
    begin
        logic [CFG_W-1:0] first_rows [PHASES];
        logic [CFG_W-1:0] first_cols [PHASES];
        int               sender_idle [PHASES];
        int               receiver_stall [PHASES];
        int unsigned      target;
        int               roll;

        // each phase opens on an extreme setting: max rows, above-max cols,
        // above-max rows with zero cols, zero rows with max cols
        first_rows     = '{CFG_W'(MAX_DIM), CFG_W'(2), CFG_W'(31), CFG_W'(0)};
        first_cols     = '{CFG_W'(3), CFG_W'(31), CFG_W'(0), CFG_W'(MAX_DIM)};
        sender_idle    = '{0, 61, 0, 33};
        receiver_stall = '{0, 0, 61, 33};

        board      = new();
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        entry_in   = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        cfg_writes = 0;
        eff_rows   = MAX_DIM;
        eff_cols   = MAX_DIM;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 1x1 with zero rows acting as one, product extremes,
        // matrix entry with is_last only stores, vectors closed too long
        configure(CFG_W'(0), CFG_W'(1));
        write_config(REG_SPARE_A, '1);
        write_config(REG_SPARE_B, CFG_W'(5));
        load(KIND_MATRIX, 0, 0, 16'sh7FFF, 1'b0);
        load(KIND_VECTOR, 0, 0, 16'sh7FFF, 1'b1);
        load(KIND_MATRIX, 0, 0, 16'sh8000, 1'b1);
        load(KIND_VECTOR, 0, 0, 16'sh8000, 1'b1);
        load(KIND_VECTOR, 9, 0, 16'sh7FFF, 1'b1);
        load(KIND_VECTOR, 15, 15, 16'shFFFF, 1'b1);
        load(KIND_VECTOR, 0, 1, 16'sh0005, 1'b1);
        load(KIND_VECTOR, 3, 7, 16'sh007B, 1'b0);
        load(KIND_MATRIX, 15, 15, 16'sh7FFF, 1'b1);
        load(KIND_MATRIX, 3, 9, 16'shFFFF, 1'b0);

        // 2x2 with sums of extreme products, then a vector closed one short
        configure(CFG_W'(2), CFG_W'(2));
        load(KIND_MATRIX, 0, 0, 16'sh8000, 1'b0);
        load(KIND_MATRIX, 0, 1, 16'sh8000, 1'b0);
        load(KIND_MATRIX, 1, 0, 16'sh7FFF, 1'b0);
        load(KIND_MATRIX, 1, 1, 16'sh8000, 1'b0);
        load(KIND_VECTOR, 0, 0, 16'sh8000, 1'b0);
        load(KIND_VECTOR, 15, 1, 16'sh8000, 1'b1);
        load(KIND_VECTOR, 0, 0, 16'sh0100, 1'b1);

        // random part, one idling pattern per phase
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct  = sender_idle[p];
            stall_pct = receiver_stall[p];
            configure(first_rows[p], first_cols[p]);
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    run_product();
                else if (roll < 80)
                    send_bad_length();
                else if (roll < 88)
                    send_noise();
                else if (roll < 96)
                    configure_random();
                else
                    settle();
            end
        end

        settle();
        $display("covered %0d input transfers, %0d results (%0d size errors)",
                 items_sent, board.results_seen, board.size_errors);
        $display("%0d register writes; idling phases: none, sender only, receiver only, both",
                 cfg_writes);
        $display("%0d mismatches", board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_cell.sv
rtl/matrix_vector_multiply.sv
dv/mvm_tb_pkg.sv
dv/tb_matrix_vector_multiply.sv
